>>> rtl/kick_drum_wavetable_voice_top_assert.svh
// Assertion macros for the kick drum wavetable voice.
`ifndef KICK_DRUM_WAVETABLE_VOICE_TOP_ASSERT_SVH
`define KICK_DRUM_WAVETABLE_VOICE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define KDW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Check that a trigger is followed by a consequence in the next cycle.
`define KDW_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define KDW_ASSERT(lbl, prop, msg)
`define KDW_ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

>>> rtl/kdw_pkg.sv
// Shared types and codes for the kick drum wavetable voice.
`timescale 1ns / 1ps
`default_nettype none
package kdw_pkg;

    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 8;
    localparam int WORD_W   = 32;
    localparam int SAMPLE_W = 8;
    localparam int CFG_IDX_W = 3;

    typedef logic [MODE_W-1:0]          t_mode;
    typedef logic [INDEX_W-1:0]         t_index;
    typedef logic [WORD_W-1:0]          t_word;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    // Input item modes
    localparam t_mode MODE_TICK      = 3'd0;
    localparam t_mode MODE_NOTE_ON   = 3'd1;
    localparam t_mode MODE_WR_PITCH  = 3'd2;
    localparam t_mode MODE_WR_SINE   = 3'd3;
    localparam t_mode MODE_WR_ENV    = 3'd4;

    // Configuration register indexes
    localparam t_cfg_idx REG_AMP_INC     = 3'd0;
    localparam t_cfg_idx REG_PITCH_SPEED = 3'd1;
    localparam t_cfg_idx REG_PITCH_END   = 3'd2;
    localparam t_cfg_idx REG_AMP_END     = 3'd3;
    localparam t_cfg_idx REG_SINE_WRAP   = 3'd4;

endpackage
`default_nettype wire

>>> rtl/kdw_if.sv
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface kdw_in_if import kdw_pkg::*; ();
    logic   valid;
    logic   ready;
    t_mode  mode;
    t_index entry_index;
    t_word  entry_value;

    modport source (output valid, output mode, output entry_index, output entry_value,
                    input ready);
    modport sink   (input valid, input mode, input entry_index, input entry_value,
                    output ready);
endinterface

interface kdw_out_if import kdw_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    playing;

    modport source (output valid, output sample, output playing, input ready);
    modport sink   (input valid, input sample, input playing, output ready);
endinterface

interface kdw_cfg_if import kdw_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_word    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/kick_drum_wavetable_voice_top.sv
// Registered in turn from input transfer to result valid: table read, sine read, output.
// Throughput: one item per cycle; the phase accumulator add/wrap closes its loop in stage 1
// against the registered pitch-table read, and the sine table is read from its result.
// Backpressure stalls each stage only when the stage after it is full.
// Reset clears positions, phase, note state, configuration and pipeline valids;
// both ready outputs stay low in reset, and the three tables hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none
`include "kick_drum_wavetable_voice_top_assert.svh"
module kick_drum_wavetable_voice_top import kdw_pkg::*; #(
    parameter int PITCH_DEPTH = 256,
    parameter int SINE_DEPTH  = 256,
    parameter int ENV_DEPTH   = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kdw_in_if.sink    i_in,
    kdw_out_if.source o_out,
    kdw_cfg_if.sink   i_cfg
);

    localparam int PAW = $clog2(PITCH_DEPTH);
    localparam int SAW = $clog2(SINE_DEPTH);
    localparam int EAW = $clog2(ENV_DEPTH);
    localparam t_word PITCH_LAST = 32'(PITCH_DEPTH - 1);
    localparam t_word SINE_LAST  = 32'(SINE_DEPTH - 1);
    localparam t_word ENV_LAST   = 32'(ENV_DEPTH - 1);

    // Position to table index: drop fraction, clamp to the last entry
    function automatic t_word f_to_index(input t_word pos, input t_word last);
        t_word idx;
        begin
            idx = pos >> FRAC_BITS;
            f_to_index = (idx > last) ? last : idx;
        end
    endfunction

    // Configuration registers
    t_word r_amp_inc, r_pitch_speed, r_pitch_end, r_amp_end, r_sine_wrap;

    // Voice state
    t_word r_phase_acc, r_pitch_pos, r_env_pos;
    logic  r_note_active;
    t_word n_pitch_pos, n_env_pos;
    logic  n_note_active;

    // Table memories
    t_word         pitch_mem [PITCH_DEPTH];
    logic signed [7:0] sine_mem [SINE_DEPTH];
    logic [7:0]    env_mem   [ENV_DEPTH];

    // Pipeline registers
    logic r1_valid, r1_run, r1_amp_on, r1_note_on, r1_playing;
    t_word r1_pitch_data;
    logic [7:0] r1_env_data;
    logic r2_valid, r2_playing;
    logic [7:0] r2_amp;
    logic signed [7:0] r2_sine;
    logic r3_valid, r3_playing;
    t_sample r3_sample;

    // Stage enables
    logic w_en1, w_en2, w_en3, w_acc_in;
    assign w_en3 = !r3_valid || o_out.ready;
    assign w_en2 = !r2_valid || w_en3;
    assign w_en1 = !r1_valid || w_en2;
    assign i_in.ready = w_en1 && i_rst_n;
    assign w_acc_in = i_in.valid && i_in.ready;

    // Configuration writes, ready whenever out of reset
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_inc     <= '0;
            r_pitch_speed <= '0;
            r_pitch_end   <= '0;
            r_amp_end     <= '0;
            r_sine_wrap   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_AMP_INC:     r_amp_inc     <= i_cfg.data;
                REG_PITCH_SPEED: r_pitch_speed <= i_cfg.data;
                REG_PITCH_END:   r_pitch_end   <= i_cfg.data;
                REG_AMP_END:     r_amp_end     <= i_cfg.data;
                REG_SINE_WRAP:   r_sine_wrap   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stage 0: advance envelope and pitch positions, form table addresses
    logic  w_is_tick, w_run, w_note_on, w_env_lt, w_pitch_lt;
    t_word w_env_next, w_pitch_next, w_env_idx, w_pitch_idx;

    assign w_is_tick    = (i_in.mode == MODE_TICK);
    assign w_note_on    = (i_in.mode == MODE_NOTE_ON);
    assign w_run        = w_is_tick && r_note_active;
    assign w_env_lt     = r_env_pos < r_amp_end;
    assign w_pitch_lt   = r_pitch_pos < r_pitch_end;
    assign w_env_next   = r_env_pos + r_amp_inc;
    assign w_pitch_next = r_pitch_pos + r_pitch_speed;
    assign w_env_idx    = f_to_index(w_env_next, ENV_LAST);
    assign w_pitch_idx  = w_pitch_lt ? f_to_index(w_pitch_next, PITCH_LAST) : PITCH_LAST;

    always_comb begin
        n_env_pos     = r_env_pos;
        n_pitch_pos   = r_pitch_pos;
        n_note_active = r_note_active;
        if (w_acc_in) begin
            if (w_note_on) begin
                n_env_pos     = '0;
                n_pitch_pos   = '0;
                n_note_active = 1'b1;
            end else if (w_run) begin
                if (w_env_lt) begin
                    n_env_pos = w_env_next;
                end else begin
                    n_note_active = 1'b0;
                end
                if (w_pitch_lt) begin
                    n_pitch_pos = w_pitch_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_pos     <= '0;
            r_pitch_pos   <= '0;
            r_note_active <= 1'b0;
        end else begin
            r_env_pos     <= n_env_pos;
            r_pitch_pos   <= n_pitch_pos;
            r_note_active <= n_note_active;
        end
    end

    // Table write addresses; drop writes beyond a table
    t_word w_wr_addr;
    logic  w_wr_pitch, w_wr_sine, w_wr_env;
    assign w_wr_addr  = {24'd0, i_in.entry_index};
    assign w_wr_pitch = w_acc_in && (i_in.mode == MODE_WR_PITCH)
                        && (w_wr_addr < 32'(PITCH_DEPTH));
    assign w_wr_sine  = w_acc_in && (i_in.mode == MODE_WR_SINE)
                        && (w_wr_addr < 32'(SINE_DEPTH));
    assign w_wr_env   = w_acc_in && (i_in.mode == MODE_WR_ENV)
                        && (w_wr_addr < 32'(ENV_DEPTH));

    // Pitch and envelope memories: write on transfer, registered read into stage 1.
    // A later write lands at or after the edge of any earlier read, so read-first order holds.
    always_ff @(posedge i_clk) begin
        if (w_wr_pitch) begin
            pitch_mem[w_wr_addr[PAW-1:0]] <= i_in.entry_value;
        end
        if (w_en1) begin
            r1_pitch_data <= pitch_mem[w_pitch_idx[PAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_env) begin
            env_mem[w_wr_addr[EAW-1:0]] <= i_in.entry_value[7:0];
        end
        if (w_en1) begin
            r1_env_data <= env_mem[w_env_idx[EAW-1:0]];
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en1) begin
            r1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_run     <= w_run;
            r1_amp_on  <= w_env_lt;
            r1_note_on <= w_note_on;
            r1_playing <= n_note_active;
        end
    end

    // Stage 1: accumulate phase, wrap once, address the sine table
    t_word w_phase_sum, w_phase_new, w_sine_idx;
    logic  w_adv1;
    assign w_adv1      = r1_valid && w_en2;
    assign w_phase_sum = r_phase_acc + r1_pitch_data;
    assign w_phase_new = (w_phase_sum >= r_sine_wrap) ? w_phase_sum - r_sine_wrap : w_phase_sum;
    assign w_sine_idx  = f_to_index(w_phase_new, SINE_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
        end else if (w_adv1 && r1_note_on) begin
            r_phase_acc <= '0;
        end else if (w_adv1 && r1_run) begin
            r_phase_acc <= w_phase_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_sine) begin
            sine_mem[w_wr_addr[SAW-1:0]] <= i_in.entry_value[7:0];
        end
        if (w_en2) begin
            r2_sine <= sine_mem[w_sine_idx[SAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_amp     <= (r1_run && r1_amp_on) ? r1_env_data : 8'd0;
            r2_playing <= r1_playing;
        end
    end

    // Stage 2: scale sine by amplitude, divide by 256 toward zero
    logic signed [8:0]  w_amp_s;
    logic signed [16:0] w_prod, w_biased;
    t_sample            w_sample;
    assign w_amp_s  = {1'b0, r2_amp};
    assign w_prod   = w_amp_s * r2_sine;
    assign w_biased = w_prod + (w_prod[16] ? 17'sd255 : 17'sd0);
    assign w_sample = (r2_amp != 8'd0) ? w_biased[15:8] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_sample  <= w_sample;
            r3_playing <= r2_playing;
        end
    end

    assign o_out.valid   = r3_valid;
    assign o_out.sample  = r3_sample;
    assign o_out.playing = r3_playing;

    // Checks
    `KDW_ASSERT(a_silent_zero, (o_out.valid && !o_out.playing) |-> (o_out.sample == '0), "sample not zero while silent")
    `KDW_ASSERT_NEXT(a_note_on_clears, w_acc_in && w_note_on, r_note_active && (r_env_pos == '0) && (r_pitch_pos == '0), "note on did not restart voice")
    `KDW_ASSERT_NEXT(a_idle_tick_holds, w_acc_in && w_is_tick && !r_note_active, $stable(r_env_pos) && $stable(r_pitch_pos) && !r_note_active, "silent tick moved positions")

endmodule
`default_nettype wire

>>> tb/sv/kick_drum_wavetable_voice_checker.sv
// Transfer monitor, voice predictor and result comparison for the kick drum voice.
`timescale 1ns / 1ps
module kick_drum_wavetable_voice_checker import kdw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    kdw_in_if    i_in_ch,
    kdw_out_if   i_out_ch,
    kdw_cfg_if   i_cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int TABLE_LEN = 256;
    localparam int FRAC      = 16;

    typedef struct packed {
        t_sample sample;
        logic    playing;
    } t_voice_out;

    // Register copies
    t_word amp_step;
    t_word sweep_step;
    t_word sweep_stop;
    t_word amp_stop;
    t_word wrap_point;

    // Voice state and tables
    t_word             phase;
    t_word             sweep_pos;
    t_word             env_pos;
    logic              sounding;
    t_word             pitch_tab [TABLE_LEN];
    logic signed [7:0] sine_tab  [TABLE_LEN];
    logic [7:0]        env_tab   [TABLE_LEN];

    t_voice_out expected_samples [$];
    int         fails = 0;

    assign o_fail_count = fails;

    // Reduce a fixed-point position to a table entry, clamped to the last one
    function automatic int unsigned entry_of(t_word pos);
        t_word e;
        e = pos >> FRAC;
        return (e > TABLE_LEN - 1) ? TABLE_LEN - 1 : e;
    endfunction

    // Advance the voice by one input item and return the sample it yields
    function automatic t_voice_out next_sample(t_mode m, t_index a, t_word d);
        t_voice_out r;
        int         amp;
        int         sine;
        int         scaled;
        r.sample = '0;
        case (m)
            MODE_TICK: begin
                if (sounding) begin
                    // envelope: advance, or end the note
                    if (env_pos < amp_stop) begin
                        env_pos += amp_step;
                        amp = int'(env_tab[entry_of(env_pos)]);
                    end else begin
                        sounding = 1'b0;
                        amp = 0;
                    end
                    // pitch sweep feeds the phase, then hold the last increment
                    if (sweep_pos < sweep_stop) begin
                        sweep_pos += sweep_step;
                        phase += pitch_tab[entry_of(sweep_pos)];
                    end else begin
                        phase += pitch_tab[TABLE_LEN-1];
                    end
                    if (phase >= wrap_point)
                        phase -= wrap_point;
                    sine = int'(sine_tab[entry_of(phase)]);
                    scaled = (amp * sine) / 256;
                    r.sample = scaled[SAMPLE_W-1:0];
                end
            end
            MODE_NOTE_ON: begin
                phase = '0;
                sweep_pos = '0;
                env_pos = '0;
                sounding = 1'b1;
            end
            MODE_WR_PITCH: pitch_tab[a] = d;
            MODE_WR_SINE:  sine_tab[a] = d[7:0];
            MODE_WR_ENV:   env_tab[a] = d[7:0];
            default: ;
        endcase
        r.playing = sounding;
        return r;
    endfunction

    // Watch all three channels: register writes, results, then new items
    always @(posedge i_clk) begin
        t_voice_out want;
        if (!i_rst_n) begin
            amp_step = '0;
            sweep_step = '0;
            sweep_stop = '0;
            amp_stop = '0;
            wrap_point = '0;
            phase = '0;
            sweep_pos = '0;
            env_pos = '0;
            sounding = 1'b0;
            expected_samples.delete();
        end else begin
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                case (i_cfg_ch.index)
                    REG_AMP_INC:     amp_step = i_cfg_ch.data;
                    REG_PITCH_SPEED: sweep_step = i_cfg_ch.data;
                    REG_PITCH_END:   sweep_stop = i_cfg_ch.data;
                    REG_AMP_END:     amp_stop = i_cfg_ch.data;
                    REG_SINE_WRAP:   wrap_point = i_cfg_ch.data;
                    default: ;
                endcase
            end
            // compare against the oldest prediction
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_samples.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got sample %0d playing %0b",
                             $time, i_out_ch.sample, i_out_ch.playing);
                end else begin
                    want = expected_samples.pop_front();
                    if (i_out_ch.sample !== want.sample || i_out_ch.playing !== want.playing)
                    begin
                        fails++;
                        $display("%0t: mismatch, expected sample %0d playing %0b, got sample %0d playing %0b",
                                 $time, want.sample, want.playing,
                                 i_out_ch.sample, i_out_ch.playing);
                    end
                end
            end
            if (i_in_ch.valid && i_in_ch.ready)
                expected_samples.push_back(next_sample(i_in_ch.mode, i_in_ch.entry_index,
                                                       i_in_ch.entry_value));
        end
        o_pending <= expected_samples.size();
    end

endmodule

>>> tb/sv/kick_drum_wavetable_voice_top_tb.sv
// Stimulus, flow control and verdict for the kick drum voice testbench.
`timescale 1ns / 1ps
module kick_drum_wavetable_voice_top_tb;
    import kdw_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 64;
    localparam int PHASE_ITEMS  = 20;
    localparam int NUM_PHASES   = 6;
    localparam int TABLE_LEN    = 256;

    typedef struct {
        t_word amp_inc;
        t_word pitch_speed;
        t_word pitch_end;
        t_word amp_end;
        t_word sine_wrap;
    } t_voice_setting;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   in_count = 0;
    int   out_count = 0;
    int   cfg_count = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;

    kdw_in_if  in_ch();
    kdw_out_if out_ch();
    kdw_cfg_if cfg_ch();

    kick_drum_wavetable_voice_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    kick_drum_wavetable_voice_checker voice_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_ch     (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Count transfers and stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready)
            in_count <= in_count + 1;
        if (out_ch.valid && out_ch.ready)
            out_count <= out_count + 1;
        if (cfg_ch.valid && cfg_ch.ready)
            cfg_count <= cfg_count + 1;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: stall styles in random stretches, one long hold-off under load
    initial begin
        int stretch;
        int style;
        bit held;
        stretch = 0;
        style = 0;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && out_count >= HOLD_AT && in_ch.valid) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (stretch == 0) begin
                stretch = $urandom_range(16, 96);
                style = $urandom_range(0, 2);
            end
            stretch--;
            case (style)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Offer one item; open a new burst after a random gap when the last one ran out
    task automatic send_voice_item(t_mode m, t_index a, t_word d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= m;
        in_ch.entry_index <= a;
        in_ch.entry_value <= d;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Hold off until every predicted result has arrived, then let the pipe settle
    task automatic drain_voice();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx r, t_word v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic program_voice(t_voice_setting s);
        write_reg(REG_AMP_INC, s.amp_inc);
        write_reg(REG_PITCH_SPEED, s.pitch_speed);
        write_reg(REG_PITCH_END, s.pitch_end);
        write_reg(REG_AMP_END, s.amp_end);
        write_reg(REG_SINE_WRAP, s.sine_wrap);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random word with extra weight on all-zeros and all-ones
    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly ticks with occasional note-ons, mixed with table rewrites and unused modes
    task automatic random_voice_items(int count);
        int    kind;
        t_word v;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            v = pick_word();
            if (kind < 68)
                send_voice_item(MODE_TICK, t_index'($urandom_range(0, 255)), v);
            else if (kind < 71)
                send_voice_item(MODE_NOTE_ON, t_index'($urandom_range(0, 255)), v);
            else if (kind < 79) begin
                if ($urandom_range(0, 9) < 7)
                    v = $urandom_range(0, 32'h000F_FFFF);
                send_voice_item(MODE_WR_PITCH, t_index'($urandom_range(0, 255)), v);
            end else if (kind < 87)
                send_voice_item(MODE_WR_SINE, t_index'($urandom_range(0, 255)), v);
            else if (kind < 95)
                send_voice_item(MODE_WR_ENV, t_index'($urandom_range(0, 255)), v);
            else
                send_voice_item(t_mode'($urandom_range(5, 7)),
                                t_index'($urandom_range(0, 255)), v);
        end
    endtask

    initial begin
        t_voice_setting plan [NUM_PHASES];
        t_voice_setting peak;
        t_voice_setting sweep;
        int             i;

        in_ch.valid       <= 1'b0;
        in_ch.mode        <= MODE_TICK;
        in_ch.entry_index <= '0;
        in_ch.entry_value <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_AMP_INC;
        cfg_ch.data       <= '0;
        i_rst_n           <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every table entry so that no read ever hits an unwritten one
        for (i = 0; i < TABLE_LEN; i++) begin
            send_voice_item(MODE_WR_PITCH, t_index'(i), $urandom_range(0, 32'h000F_FFFF));
            send_voice_item(MODE_WR_SINE, t_index'(i), $urandom);
            send_voice_item(MODE_WR_ENV, t_index'(i), $urandom);
        end
        drain_voice();

        // Registers at their reset values: silent tick, unused modes, instant note end
        send_voice_item(MODE_TICK, 8'd0, 32'h0000_0000);
        send_voice_item(t_mode'(5), 8'd255, 32'hFFFF_FFFF);
        send_voice_item(t_mode'(6), 8'd0, 32'h0000_0000);
        send_voice_item(t_mode'(7), 8'd255, 32'hFFFF_FFFF);
        send_voice_item(MODE_NOTE_ON, 8'd0, 32'h0000_0000);
        send_voice_item(MODE_TICK, 8'd0, 32'h0000_0000);
        send_voice_item(MODE_TICK, 8'd255, 32'hFFFF_FFFF);
        // Table extremes: last pitch step all ones, sine at both rails, full envelope
        send_voice_item(MODE_WR_PITCH, 8'd255, 32'hFFFF_FFFF);
        send_voice_item(MODE_WR_PITCH, 8'd0, 32'h0000_0000);
        send_voice_item(MODE_WR_SINE, 8'd0, 32'h0000_0080);
        send_voice_item(MODE_WR_SINE, 8'd255, 32'hFFFF_FF7F);
        send_voice_item(MODE_WR_ENV, 8'd0, 32'h0000_00FF);
        send_voice_item(MODE_WR_ENV, 8'd255, 32'hFFFF_FFFF);
        drain_voice();

        // Clamped indexes at full amplitude: largest positive, then largest negative sample
        peak = '{32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000};
        program_voice(peak);
        send_voice_item(MODE_NOTE_ON, 8'd0, 32'h0000_0000);
        send_voice_item(MODE_TICK, 8'd0, 32'h0000_0000);
        send_voice_item(MODE_WR_SINE, 8'd255, 32'h0000_0080);
        send_voice_item(MODE_TICK, 8'd0, 32'h0000_0000);
        drain_voice();

        // Short note: sweep reaches its end, then the envelope runs out
        sweep = '{32'h0001_0000, 32'h0004_0000, 32'h0010_0000, 32'h0006_0000, 32'h0100_0000};
        program_voice(sweep);
        send_voice_item(MODE_NOTE_ON, 8'd0, 32'h0000_0000);
        repeat (7) send_voice_item(MODE_TICK, t_index'($urandom_range(0, 255)), pick_word());
        drain_voice();

        // Random phases, each under its own register setting and opened by a note
        plan[0] = '{32'h0010_0000, 32'h0004_0000, 32'h0080_0000, 32'h00FF_0000, 32'h0100_0000};
        plan[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        plan[2] = '{32'h0004_0000, 32'h0000_1000, 32'h0100_0000, 32'h00FF_0000, 32'h0040_0000};
        plan[3] = '{$urandom, $urandom, $urandom, $urandom, $urandom};
        plan[4] = '{32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 32'h0200_0000, 32'h0000_0000};
        plan[5] = '{32'h1000_0000, 32'h2000_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h8000_0000};
        for (i = 0; i < NUM_PHASES; i++) begin
            program_voice(plan[i]);
            send_voice_item(MODE_NOTE_ON, 8'd0, 32'h0000_0000);
            random_voice_items(PHASE_ITEMS);
            drain_voice();
        end

        $display("covered %0d items and %0d results over %0d register writes",
                 in_count, out_count, cfg_count);
        $display("table preload, rail samples, note ends, sweep holds, wraps and a long stall");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/kdw_pkg.sv
rtl/kdw_if.sv
rtl/kick_drum_wavetable_voice_top.sv
tb/sv/kick_drum_wavetable_voice_checker.sv
tb/sv/kick_drum_wavetable_voice_top_tb.sv
